// File: rtl/npe_pkg.sv
`default_nettype none

package npe_pkg;

   // Width of one sequence element.
   localparam int DATA_W = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // an input transfer completes this cycle
      logic pivot_init;   // start the pivot scan at the end of the sequence
      logic emit_init;    // point the scan index at the first element
      logic rd_pivot;     // read the neighbor pair at scan-1 and scan
      logic rd_rev;       // read the pair at lo and hi
      logic pivot_found;  // latch the pivot and restart the scan for its successor
      logic wrap;         // no ascent: set up a reversal of the whole sequence
      logic scan_dec;     // step the scan index toward the front
      logic scan_inc;     // step the scan index toward the back
      logic write_p;      // store the successor at the pivot position
      logic write_j;      // store the pivot at the successor position
      logic rev_wa;       // store the hi element at lo
      logic rev_wb;       // store the lo element at hi and move both ends inward
      logic out_load;     // capture the element being emitted
      logic seq_done;     // sequence finished, clear count, drop and wrap flags
   } npe_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic multi;        // two or more elements are stored
      logic ascent;       // the pair just read is strictly increasing
      logic at_first;     // the pivot scan has reached the first pair
      logic found;        // the element just read is larger than the pivot
      logic lo_lt_hi;     // the reversal still has a pair to swap
      logic emit_last;    // the captured element is the final one
   } npe_status_type;

endpackage

`default_nettype wire

// File: rtl/npe_ram.sv
`default_nettype none

module npe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

`default_nettype wire

// File: rtl/npe_ctrl.sv
`default_nettype none

module npe_ctrl
   import npe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   input  wire logic           req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire npe_status_type status,
   output npe_cmd_type         cmd
);

   typedef enum logic [12:0] {
      ST_LOAD      = 13'b0000000000001,
      ST_START     = 13'b0000000000010,
      ST_PIV_RD    = 13'b0000000000100,
      ST_PIV_CMP   = 13'b0000000001000,
      ST_SUC_RD    = 13'b0000000010000,
      ST_SUC_CMP   = 13'b0000000100000,
      ST_SWAP      = 13'b0000001000000,
      ST_REV_RD    = 13'b0000010000000,
      ST_REV_WA    = 13'b0000100000000,
      ST_REV_WB    = 13'b0001000000000,
      ST_EMIT_RD   = 13'b0010000000000,
      ST_EMIT_CAP  = 13'b0100000000000,
      ST_EMIT_HOLD = 13'b1000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_EMIT_HOLD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_tlast) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (status.multi) begin
               cmd.pivot_init = 1'b1;
               state_in       = ST_PIV_RD;
            end else begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_PIV_RD: begin
            cmd.rd_pivot = 1'b1;
            state_in     = ST_PIV_CMP;
         end
         ST_PIV_CMP: begin
            priority if (status.ascent) begin
               cmd.pivot_found = 1'b1;
               state_in        = ST_SUC_RD;
            end else if (status.at_first) begin
               cmd.wrap = 1'b1;
               state_in = ST_REV_RD;
            end else begin
               cmd.scan_dec = 1'b1;
               state_in     = ST_PIV_RD;
            end
         end
         ST_SUC_RD: begin
            state_in = ST_SUC_CMP;
         end
         ST_SUC_CMP: begin
            if (status.found) begin
               cmd.write_p = 1'b1;
               state_in    = ST_SWAP;
            end else begin
               cmd.scan_dec = 1'b1;
               state_in     = ST_SUC_RD;
            end
         end
         ST_SWAP: begin
            cmd.write_j = 1'b1;
            state_in    = ST_REV_RD;
         end
         ST_REV_RD: begin
            cmd.rd_rev = 1'b1;
            if (status.lo_lt_hi) begin
               state_in = ST_REV_WA;
            end else begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_REV_WA: begin
            cmd.rev_wa = 1'b1;
            state_in   = ST_REV_WB;
         end
         ST_REV_WB: begin
            cmd.rev_wb = 1'b1;
            state_in   = ST_REV_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_CAP;
         end
         ST_EMIT_CAP: begin
            cmd.out_load = 1'b1;
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_tready) begin
               if (status.emit_last) begin
                  cmd.seq_done = 1'b1;
                  state_in     = ST_LOAD;
               end else begin
                  cmd.scan_inc = 1'b1;
                  state_in     = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/npe_dpath.sv
`default_nettype none

module npe_dpath
   import npe_pkg::*;
#(
   parameter int MAX_LEN = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire npe_cmd_type       cmd,
   output npe_status_type         status,
   input  wire logic [DATA_W-1:0] in_value,
   output logic      [DATA_W-1:0] out_value,
   output logic                   out_last,
   output logic                   out_wrapped,
   output logic                   out_overflow
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   logic [CW-1:0]     count_ff, count_in;
   logic              drop_ff, drop_in;
   logic              wrapped_ff, wrapped_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic [AW-1:0]     p_ff, p_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [DATA_W-1:0] piv_ff, piv_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic              out_last_ff, out_last_in;

   logic [CW-1:0]     count_m1;
   logic [AW-1:0]     last_idx;
   logic [AW-1:0]     scan_m1;

   logic              we;
   logic [AW-1:0]     waddr;
   logic [DATA_W-1:0] wdata;
   logic [AW-1:0]     raddr_a, raddr_b;
   logic [DATA_W-1:0] rd_a, rd_b;

   assign count_m1 = count_ff - CW'(1);
   assign last_idx = count_m1[AW-1:0];
   assign scan_m1  = scan_ff - AW'(1);

   assign raddr_a = cmd.rd_pivot ? scan_m1 : (cmd.rd_rev ? lo_ff : scan_ff);
   assign raddr_b = cmd.rd_rev ? hi_ff : scan_ff;

   npe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   // Elements compare as signed two's complement values.
   assign status.multi     = (count_ff >= CW'(2));
   assign status.ascent    = ($signed(rd_a) < $signed(rd_b));
   assign status.at_first  = (scan_ff == AW'(1));
   assign status.found     = ($signed(rd_a) > $signed(piv_ff));
   assign status.lo_lt_hi  = (lo_ff < hi_ff);
   assign status.emit_last = out_last_ff;

   always_comb begin
      count_in     = count_ff;
      drop_in      = drop_ff;
      wrapped_in   = wrapped_ff;
      scan_in      = scan_ff;
      p_in         = p_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      piv_in       = piv_ff;
      tmp_in       = tmp_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      we           = 1'b0;
      waddr        = count_ff[AW-1:0];
      wdata        = in_value;

      if (cmd.accept) begin
         if (count_ff < CW'(MAX_LEN)) begin
            we       = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.pivot_init) begin
         scan_in    = last_idx;
         wrapped_in = 1'b0;
      end
      if (cmd.emit_init) begin
         scan_in = '0;
      end
      if (cmd.pivot_found) begin
         p_in    = scan_m1;
         piv_in  = rd_a;
         scan_in = last_idx;
      end
      if (cmd.wrap) begin
         wrapped_in = 1'b1;
         lo_in      = '0;
         hi_in      = last_idx;
      end
      if (cmd.scan_dec) begin
         scan_in = scan_m1;
      end
      if (cmd.scan_inc) begin
         scan_in = scan_ff + AW'(1);
      end
      if (cmd.write_p) begin
         we    = 1'b1;
         waddr = p_ff;
         wdata = rd_a;
      end
      if (cmd.write_j) begin
         we    = 1'b1;
         waddr = scan_ff;
         wdata = piv_ff;
         lo_in = p_ff + AW'(1);
         hi_in = last_idx;
      end
      if (cmd.rev_wa) begin
         we     = 1'b1;
         waddr  = lo_ff;
         wdata  = rd_b;
         tmp_in = rd_a;
      end
      if (cmd.rev_wb) begin
         we    = 1'b1;
         waddr = hi_ff;
         wdata = tmp_ff;
         lo_in = lo_ff + AW'(1);
         hi_in = hi_ff - AW'(1);
      end
      if (cmd.out_load) begin
         out_value_in = rd_a;
         out_last_in  = (scan_ff == last_idx);
      end
      if (cmd.seq_done) begin
         count_in   = '0;
         drop_in    = 1'b0;
         wrapped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         drop_ff    <= 1'b0;
         wrapped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         drop_ff    <= drop_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      p_ff         <= p_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      piv_ff       <= piv_in;
      tmp_ff       <= tmp_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign out_value    = out_value_ff;
   assign out_last     = out_last_ff;
   assign out_wrapped  = wrapped_ff;
   assign out_overflow = drop_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEN))
      else $error("element count beyond capacity");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (count_ff == CW'(MAX_LEN)))
      else $error("drop flag set while the store is not full");

   a_succ_right: assert property (@(posedge clock) disable iff (reset)
      cmd.write_p |-> (p_ff < scan_ff))
      else $error("successor not to the right of the pivot");

   a_rev_order: assert property (@(posedge clock) disable iff (reset)
      cmd.rev_wa |-> (lo_ff < hi_ff))
      else $error("reversal swap with crossed ends");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (count_ff != '0))
      else $error("emitting from an empty sequence");

endmodule

`default_nettype wire

// File: rtl/next_permutation_engine_core.sv
`default_nettype none

// Next lexicographic permutation engine. Elements (signed 32-bit) arrive one per
// transfer on the req_ channel until a transfer with tlast set; that element belongs
// to the sequence. The block then finds the rightmost ascent (the pivot), swaps it
// with the rightmost strictly larger element and reverses the suffix behind it, and
// sends the resulting sequence on the rsp_ channel, one element per transfer with
// tlast on the final one. A sequence with no ascent is the highest permutation; it
// comes back in ascending order with the wrapped flag set. A single element comes
// back unchanged. Up to MAX_LEN elements are kept; later elements of the same
// sequence, including the tlast one, are discarded and the overflow flag is set.
// Both flags are the same on every result of a sequence. While loading, req_tready
// stays high, so an element is taken whenever req_tvalid is high. The work on one
// sequence is serialized through a single element store with one write port and
// two registered read ports: the pivot scan and the successor scan read and then
// compare at each position visited, the swap writes the successor and then the
// pivot, the reversal reads a pair and writes one end and then the other, and each
// result is read, captured and held until the sink takes it. The block does not
// accept input while a sequence is being computed or sent.
module next_permutation_engine_core
   import npe_pkg::*;
#(
   parameter int MAX_LEN = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tlast,   // last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] value_res
   output logic             rsp_tlast,   // last_res
   output logic      [1:0]  rsp_tuser    // [0] wrapped, [1] overflow
);

   npe_cmd_type    cmd;
   npe_status_type status;
   logic           out_wrapped;
   logic           out_overflow;

   // The controller sequences the load, scan, swap, reversal and emit phases.
   npe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the element store, the indices and the output register.
   npe_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_value     (req_tdata),
      .out_value    (rsp_tdata),
      .out_last     (rsp_tlast),
      .out_wrapped  (out_wrapped),
      .out_overflow (out_overflow)
   );

   assign rsp_tuser = {out_overflow, out_wrapped};

endmodule

`default_nettype wire

// File: bench/next_perm_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the permutation engine. It keeps its own copy of
// the element store, works out the next permutation whenever a transfer with
// tlast completes, and checks each result transfer against the oldest
// expected element.
module next_perm_checker
   import npe_pkg::*;
#(
   parameter int MAX_LEN = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [DATA_W-1:0] rsp_tdata,
   input  wire logic              rsp_tlast,
   input  wire logic [1:0]        rsp_tuser,
   output int                     mismatches,
   output int                     pending,
   output int                     checked,
   output int                     wraps
);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     wrapped;
      logic                     overflow;
   } perm_elem_type;

   perm_elem_type            expected_perm[$];
   logic signed [DATA_W-1:0] held_elems[MAX_LEN];
   int                       held_count;
   bit                       held_dropped;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic swap_held(input int a, input int b);
      logic signed [DATA_W-1:0] t;
      t = held_elems[a];
      held_elems[a] = held_elems[b];
      held_elems[b] = t;
   endtask

   // Rearranges the held sequence into its successor and queues the elements.
   task automatic predict_next_perm();
      int  i;
      int  pivot;
      int  succ;
      int  lo;
      int  hi;
      bit  wrap;
      perm_elem_type e;
      wrap = 1'b0;
      if (held_count >= 2) begin
         i = held_count - 1;
         while (i > 0 && held_elems[i - 1] >= held_elems[i])
            i--;
         if (i == 0) begin
            // Highest permutation: the whole sequence flips to ascending.
            wrap = 1'b1;
            lo = 0;
         end else begin
            pivot = i - 1;
            succ = held_count - 1;
            while (held_elems[succ] <= held_elems[pivot])
               succ--;
            swap_held(pivot, succ);
            lo = pivot + 1;
         end
         hi = held_count - 1;
         while (lo < hi) begin
            swap_held(lo, hi);
            lo++;
            hi--;
         end
      end
      for (int k = 0; k < held_count; k++) begin
         e.value = held_elems[k];
         e.last = (k == held_count - 1);
         e.wrapped = wrap;
         e.overflow = held_dropped;
         expected_perm.push_back(e);
      end
      if (wrap)
         wraps++;
      held_count = 0;
      held_dropped = 1'b0;
   endtask

   always @(posedge clock) begin
      perm_elem_type want;
      if (reset) begin
         expected_perm.delete();
         held_count = 0;
         held_dropped = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_perm.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         $signed(rsp_tdata)));
            end else begin
               want = expected_perm.pop_front();
               checked++;
               if (rsp_tdata !== want.value)
                  report_mismatch($sformatf("value %0d, expected %0d",
                                            $signed(rsp_tdata), want.value));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("tlast %b, expected %b", rsp_tlast, want.last));
               if (rsp_tuser[0] !== want.wrapped)
                  report_mismatch($sformatf("wrapped %b, expected %b",
                                            rsp_tuser[0], want.wrapped));
               if (rsp_tuser[1] !== want.overflow)
                  report_mismatch($sformatf("overflow %b, expected %b",
                                            rsp_tuser[1], want.overflow));
            end
         end
         if (req_tvalid && req_tready) begin
            if (held_count < MAX_LEN) begin
               held_elems[held_count] = req_tdata;
               held_count++;
            end else begin
               held_dropped = 1'b1;
            end
            if (req_tlast)
               predict_next_perm();
         end
         pending = expected_perm.size();
      end
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// Top of the permutation engine bench. It generates the clock and reset,
// sends element sequences on the request channel, throttles the response
// channel, and gives the verdict. All checking lives in next_perm_checker.
module tb_top;
   import npe_pkg::*;

   localparam int MAX_LEN = 16;
   localparam int ITEM_TARGET = 430;
   // Enough cycles for the slowest sequence to finish after its last element.
   localparam int SETTLE_CYCLES = 160;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic [1:0]        rsp_tuser;

   int mismatches;
   int pending;
   int checked;
   int wraps;

   int items_sent = 0;
   int seqs_sent = 0;
   int overflow_seqs = 0;
   int drains = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   next_permutation_engine_core #(
      .MAX_LEN(MAX_LEN)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   next_perm_checker #(
      .MAX_LEN(MAX_LEN)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .mismatches(mismatches),
      .pending(pending),
      .checked(checked),
      .wraps(wraps)
   );

   // Response sink. After every transfer it draws a random stall length and holds
   // tready low for that long. Now and then it switches into a
   // calm mode where it never stalls, so back-to-back transfers occur too.
   int unsigned rsp_stall = 0;
   int unsigned rsp_draw;
   bit          rsp_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 31) == 0)
            rsp_calm <= ~rsp_calm;
         rsp_draw = rsp_calm ? 0 : $urandom_range(0, 16);
         rsp_stall <= rsp_draw;
         rsp_tready <= (rsp_draw == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Presents one element and waits for its transfer. The gap before it is
   // drawn per element unless the sequence runs calm. When no gap is drawn,
   // tvalid simply stays high from the previous transfer.
   task automatic send_element(input int value, input bit last, input bit calm);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= value;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Sends a whole sequence, tlast on its final element.
   task automatic send_sequence(input int vals[$]);
      bit calm;
      calm = ($urandom_range(0, 3) == 0);
      foreach (vals[k])
         send_element(vals[k], k == vals.size() - 1, calm);
      seqs_sent++;
      if (vals.size() > MAX_LEN)
         overflow_seqs++;
   endtask

   // Holds off the sender until every expected result has been taken. The
   // first edge lets the checker account for the transfer that just happened.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      drains++;
   endtask

   initial begin
      int vals[$];
      int len;
      int style;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A single element comes back unchanged and never wraps.
      send_sequence('{32'sh7fff_ffff});
      // The most negative value below the most positive one is an ascent
      // only under a signed compare.
      send_sequence('{32'sh8000_0000, 32'sh7fff_ffff});
      // Strictly descending across the extremes: wraps to ascending.
      send_sequence('{32'sh7fff_ffff, 0, 32'sh8000_0000});
      // Repeated values around the pivot: the successor is the rightmost
      // element strictly greater than the pivot, giving 2, 1, 2, 3.
      send_sequence('{1, 3, 2, 2});
      // Equal elements form no ascent, so this counts as the highest order.
      send_sequence('{-1, -1});
      drain_results();

      // A full store in descending order plus one more, larger element. The
      // extra element carries tlast and must be dropped, so the result wraps
      // and flags the overflow.
      vals.delete();
      for (int k = 0; k < MAX_LEN; k++)
         vals.push_back(15 - k);
      vals.push_back(999);
      send_sequence(vals);

      // Random sequences. Lengths are mostly short, with some full stores and
      // a few overlong ones. Contents are wide random values, narrow ranges
      // that give many repeats, extreme values, or descending runs that wrap.
      while (items_sent < ITEM_TARGET) begin
         vals.delete();
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: len = $urandom_range(1, 6);
            12, 13, 14, 15:                       len = $urandom_range(7, 16);
            16, 17:                               len = MAX_LEN;
            default:                              len = $urandom_range(17, 20);
         endcase
         style = $urandom_range(0, 4);
         for (int k = 0; k < len; k++) begin
            case (style)
               0, 3: vals.push_back(int'($urandom));
               1, 4: vals.push_back(int'($urandom_range(0, 6)) - 3);
               default: begin
                  case ($urandom_range(0, 3))
                     0:       vals.push_back(32'sh8000_0000);
                     1:       vals.push_back(32'sh7fff_ffff);
                     2:       vals.push_back(-1);
                     default: vals.push_back(0);
                  endcase
               end
            endcase
         end
         if (style >= 3)
            vals.rsort();
         send_sequence(vals);
         if ($urandom_range(0, 7) == 0)
            drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d elements in %0d sequences; %0d results checked.",
               items_sent, seqs_sent, checked);
      $display("%0d sequences wrapped, %0d overran the store, %0d full drains.",
               wraps, overflow_seqs, drains);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("Run limit reached with %0d results still expected.", pending);
      $display("FAIL");
      $finish;
   end

endmodule
